FILE: design/fmo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmo_pkg
// Shared types, constants and the quarter-wave sine table of the FM
// oscillator.
// ----------------------------------------------------------------------------
package fmo_pkg;

    localparam int SINE_ADDR_BITS = 10;
    localparam int PHASE_BITS     = 32;

    localparam int SAMPLE_W = 16;
    localparam int REG_W    = 32;
    localparam int GAIN_W   = 16;
    localparam int PROD_W   = SAMPLE_W + REG_W;
    localparam int DEV_SHIFT = 15;
    localparam int GPROD_W  = SAMPLE_W + GAIN_W + 1;
    localparam int GAIN_FRAC = 12;
    localparam int RND_W    = GPROD_W - GAIN_FRAC;

    localparam int QUARTER = (2 ** SINE_ADDR_BITS) / 4;
    localparam int QUARTER_SHIFT = SINE_ADDR_BITS - 2;
    localparam int QIDX_W  = SINE_ADDR_BITS - 1;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_INC  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DEV_STEP  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_START_PH  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_GAIN  = CFG_IDX_W'(3);

    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(4096);

    typedef logic [SAMPLE_W-1:0] t_qtab [0:QUARTER];

    // Controller to datapath: one strobe per sequencing step.
    typedef struct packed {
        logic load_mul;
        logic step_phase;
        logic read_rom;
        logic mul_gain;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

    // Unsigned quotient by shift and subtract, used only while building the table.
    function automatic longint unsigned f_udiv(longint unsigned num, longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Quarter wave 32767*sin(k*pi/2/QUARTER), Taylor series in Q30.
    function automatic t_qtab f_build_qtab();
        t_qtab             tab;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   term;
        longint unsigned   v;
        longint            sum;
        for (int k = 0; k <= QUARTER; k++) begin
            x    = (longint'(k) * HALF_PI_Q30 + longint'(QUARTER >> 1)) >> QUARTER_SHIFT;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 8; n++) begin
                term = f_udiv((term * x2) >> 30, 64'((2 * n) * (2 * n + 1)));
                if (n[0] == 1'b1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            v = (longint'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
            if (v > 64'd32767) begin
                v = 64'd32767;
            end
            tab[k] = v[SAMPLE_W-1:0];
        end
        return tab;
    endfunction

    localparam t_qtab QSINE = f_build_qtab();

endpackage

FILE: design/fmo_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmo_in_if
// Modulator word channel: valid/ready with sample and restart flag.
// ----------------------------------------------------------------------------
interface fmo_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] mod_sample;
    logic               restart;

    modport source (output valid, output mod_sample, output restart, input ready);
    modport sink   (input valid, input mod_sample, input restart, output ready);
endinterface

FILE: design/fmo_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmo_out_if
// PCM word channel: valid/ready with output sample and clip flag.
// ----------------------------------------------------------------------------
interface fmo_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] out_sample;
    logic               clipped;

    modport source (output valid, output out_sample, output clipped, input ready);
    modport sink   (input valid, input out_sample, input clipped, output ready);
endinterface

FILE: design/fm_sample_modulated_oscillator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fm_sample_modulated_oscillator_unit
// FM direct digital synthesis sine oscillator, one PCM word per modulator
// word.
//
// i_in carries a signed modulator sample and a restart flag; restart loads
// the phase from start_phase before the step. o_out carries the gained,
// rounded and saturated sample with its clip flag. The user must write the
// registers through i_cfg_we/i_cfg_idx/i_cfg_data only while the block is
// idle; the block itself does not enforce this. The sequencer steps the
// deviation multiply, phase add, sine lookup, gain multiply and rounding
// one after another; the next word is taken during the rounding step.
// When o_out stalls the finished word holds in the output register and the
// block stops accepting once the next word reaches rounding.
// Reset clears the phase and the sequencer, sets base, deviation and start
// phase to zero and the gain to unity (4096).
// ----------------------------------------------------------------------------
module fm_sample_modulated_oscillator_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [fmo_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [fmo_pkg::REG_W-1:0]     i_cfg_data,
    fmo_in_if.sink                        i_in,
    fmo_out_if.source                     o_out
);
    import fmo_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    in_ready;

    fmo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    fmo_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_mod_sample (i_in.mod_sample),
        .i_restart    (i_in.restart),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_out_valid  (o_out.valid),
        .i_out_ready  (o_out.ready),
        .o_out_sample (o_out.out_sample),
        .o_clipped    (o_out.clipped)
    );

    assign i_in.ready = in_ready;

endmodule

FILE: design/fmo_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmo_ctrl
// Sequencer: steps one word through phase update, lookup, gain and output.
// ----------------------------------------------------------------------------
module fmo_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  fmo_pkg::t_status i_status,
    output fmo_pkg::t_cmd   o_cmd
);
    import fmo_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_ACC  = 5'b00010,
        S_ROM  = 5'b00100,
        S_GAIN = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    // Take a new word while the previous one drains into the output register.
    assign o_in_ready = (r_state == S_IDLE) || ((r_state == S_OUT) && i_status.out_free);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_ACC;
            end
            S_ACC:  n_state = S_ROM;
            S_ROM:  n_state = S_GAIN;
            S_GAIN: n_state = S_OUT;
            S_OUT: begin
                if (i_status.out_free) begin
                    n_state = accept ? S_ACC : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.load_mul   = accept;
        o_cmd.step_phase = (r_state == S_ACC);
        o_cmd.read_rom   = (r_state == S_ROM);
        o_cmd.mul_gain   = (r_state == S_GAIN);
        o_cmd.load_out   = (r_state == S_OUT) && i_status.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: design/fmo_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmo_dp
// Datapath: registers, deviation multiply, phase accumulator, sine lookup,
// gain multiply, rounding/saturation and the output register.
// ----------------------------------------------------------------------------
module fmo_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [fmo_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [fmo_pkg::REG_W-1:0]   i_cfg_data,
    input  logic signed [15:0]          i_mod_sample,
    input  logic                        i_restart,
    input  fmo_pkg::t_cmd               i_cmd,
    output fmo_pkg::t_status            o_status,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [15:0]          o_out_sample,
    output logic                        o_clipped
);
    import fmo_pkg::*;

    localparam logic [QIDX_W-1:0] QUARTER_V = QIDX_W'(QUARTER);

    logic [REG_W-1:0]         r_base;
    logic signed [REG_W-1:0]  r_dev;
    logic [REG_W-1:0]         r_start;
    logic [GAIN_W-1:0]        r_gain;

    logic [PHASE_BITS-1:0]    r_phase;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_restart;
    logic signed [SAMPLE_W-1:0] r_rom;
    logic signed [GPROD_W-1:0]  r_gprod;
    logic                     r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_sample;
    logic                     r_clipped;

    logic [PHASE_BITS-1:0]    n_phase;
    logic [PHASE_BITS-1:0]    phase_src;
    logic signed [PROD_W-1:0] dev_full;
    logic [SINE_ADDR_BITS-1:0] addr;
    logic [QIDX_W-1:0]        qidx;
    logic [SAMPLE_W-1:0]      qval;
    logic signed [SAMPLE_W-1:0] n_rom;
    logic                     neg;
    logic [GPROD_W-1:0]       mag;
    logic [RND_W-1:0]         rnd;
    logic signed [SAMPLE_W-1:0] n_out_sample;
    logic                     n_clipped;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_dev   <= '0;
            r_start <= '0;
            r_gain  <= GAIN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BASE_INC: r_base  <= i_cfg_data;
                CFG_DEV_STEP: r_dev   <= i_cfg_data;
                CFG_START_PH: r_start <= i_cfg_data;
                CFG_OUT_GAIN: r_gain  <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Phase step: floor of product / 2^15 is an arithmetic shift.
    assign dev_full  = r_prod >>> DEV_SHIFT;
    assign phase_src = r_restart ? PHASE_BITS'(r_start) : r_phase;
    assign n_phase   = phase_src + PHASE_BITS'(r_base) + PHASE_BITS'(dev_full);

    // Quarter-wave lookup with mirror and sign from the two top address bits.
    assign addr  = r_phase[PHASE_BITS-1 -: SINE_ADDR_BITS];
    assign qidx  = addr[SINE_ADDR_BITS-2] ?
                   (QUARTER_V - {1'b0, addr[SINE_ADDR_BITS-3:0]}) :
                   {1'b0, addr[SINE_ADDR_BITS-3:0]};
    assign qval  = QSINE[qidx];
    assign n_rom = addr[SINE_ADDR_BITS-1] ? -$signed(qval) : $signed(qval);

    // Round half away from zero, then saturate.
    assign neg = r_gprod[GPROD_W-1];
    assign mag = neg ? GPROD_W'(-r_gprod) : GPROD_W'(r_gprod);
    assign rnd = RND_W'((mag + GPROD_W'(2 ** (GAIN_FRAC - 1))) >> GAIN_FRAC);

    always_comb begin
        n_clipped = 1'b0;
        if (neg) begin
            if (rnd > RND_W'(32768)) begin
                n_out_sample = -16'sd32768;
                n_clipped    = 1'b1;
            end else begin
                n_out_sample = SAMPLE_W'(-$signed({1'b0, rnd}));
            end
        end else begin
            if (rnd > RND_W'(32767)) begin
                n_out_sample = 16'sd32767;
                n_clipped    = 1'b1;
            end else begin
                n_out_sample = SAMPLE_W'(rnd);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_mul) begin
            r_prod    <= i_mod_sample * r_dev;
            r_restart <= i_restart;
        end
        if (i_cmd.read_rom) begin
            r_rom <= n_rom;
        end
        if (i_cmd.mul_gain) begin
            r_gprod <= r_rom * $signed({1'b0, r_gain});
        end
        if (i_cmd.load_out) begin
            r_out_sample <= n_out_sample;
            r_clipped    <= n_clipped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.step_phase) begin
                r_phase <= n_phase;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid  = r_out_valid;
    assign o_out_sample = r_out_sample;
    assign o_clipped    = r_clipped;

endmodule
